// ----- sv/cdw_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar day number package
// Shared widths, codes and types for the calendar day number and weekday block.
// ----------------------------------------------------------------------------
package cdw_pkg;

   localparam int MAX_MONTHS_DEF = 16;
   localparam int MAX_LEAPS_DEF  = 4;
   localparam int MAX_RULES_DEF  = 4;
   localparam int YEAR_BITS_DEF  = 12;

   localparam int PER_W  = 12;
   localparam int DAYS_W = 10;
   localparam int BASE_W = 16;
   localparam int YLEN_W = 15;
   localparam int ABS_W  = 27;
   localparam int WK_W   = 8;
   localparam int ADDR_W = 4;

   localparam logic [1:0] MODE_MONTH = 2'd0;
   localparam logic [1:0] MODE_LEAP  = 2'd1;
   localparam logic [1:0] MODE_EXC   = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   localparam logic [1:0] REG_WEEK_LENGTH = 2'd0;
   localparam logic [1:0] REG_WEEK_OFFSET = 2'd1;
   localparam logic [1:0] REG_MONTH_COUNT = 2'd2;
   localparam logic [1:0] REG_LEAP_COUNT  = 2'd3;

   typedef struct packed {
      logic [PER_W-1:0] period;
      logic [PER_W-1:0] phase;
      logic [7:0]       prio;
      logic             happens;
   } rule_entry_type;

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_MRD  = 14'b00000000000010,
      ST_MADD = 14'b00000000000100,
      ST_MUL  = 14'b00000000001000,
      ST_RRD  = 14'b00000000010000,
      ST_RCHK = 14'b00000000100000,
      ST_RDIV = 14'b00000001000000,
      ST_BASE = 14'b00000010000000,
      ST_BDIV = 14'b00000100000000,
      ST_ACC  = 14'b00001000000000,
      ST_WK   = 14'b00010000000000,
      ST_WMOD = 14'b00100000000000,
      ST_WDIV = 14'b01000000000000,
      ST_OUT  = 14'b10000000000000
   } state_type;

endpackage

// ----- sv/calendar_day_number_weekday.sv -----
// ----------------------------------------------------------------------------
// Calendar day number and weekday
// Month, leap rule and exception tables with an iterative date query engine.
// ----------------------------------------------------------------------------
// Input beats on req_ carry a mode. Modes month, leap rule and exception
// write one table entry and give no result beat. A query beat gives one
// rsp_ beat: absolute day, weekday and year length.
// A query runs on one shared restoring divider (one bit a cycle) under a
// small sequencer: months are summed one table entry at a time, then, with
// leap rules in use, every year from zero up to and including the query
// year is walked. For each leap rule in use each exception slot is read and
// checked, a valid one with a nonzero period takes a modulo on the divider,
// and the base rule takes one more modulo unless an exception decided it or
// its period is zero. req_ready stays low for the whole query, so only one
// query is in flight at a time.
// The result is held on rsp_ until taken; a stalled receiver holds the
// block. Reset is synchronous: it clears all tables and sets the registers
// to week length 7, offset 0, twelve months and no leap rules.
// The APB-style port has pready tied high; write registers only while idle.
// ----------------------------------------------------------------------------
module calendar_day_number_weekday #(
   parameter int MAX_MONTHS = cdw_pkg::MAX_MONTHS_DEF,
   parameter int MAX_LEAPS  = cdw_pkg::MAX_LEAPS_DEF,
   parameter int MAX_RULES  = cdw_pkg::MAX_RULES_DEF,
   parameter int YEAR_BITS  = cdw_pkg::YEAR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_mode,
   input  logic [3:0]                 req_table_slot,
   input  logic [1:0]                 req_rule_slot,
   input  logic [9:0]                 req_day_count,
   input  logic [11:0]                req_period,
   input  logic [11:0]                req_phase,
   input  logic [3:0]                 req_month,
   input  logic [7:0]                 req_priority_req,
   input  logic                       req_flag,
   input  logic                       req_entry_valid,
   input  logic [YEAR_BITS-1:0]       req_year,
   input  logic [9:0]                 req_day,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [26:0]                rsp_absolute_day,
   output logic [7:0]                 rsp_weekday,
   output logic [14:0]                rsp_year_length,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cdw_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int MI_W    = (MAX_MONTHS > 1) ? $clog2(MAX_MONTHS) : 1;
   localparam int LI_W    = (MAX_LEAPS > 1) ? $clog2(MAX_LEAPS) : 1;
   localparam int RDEPTH  = MAX_LEAPS * MAX_RULES;
   localparam int RA_W    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int KC_W    = $clog2(MAX_RULES + 1);
   localparam int DIFF_W  = (YEAR_BITS > cdw_pkg::PER_W) ? YEAR_BITS : cdw_pkg::PER_W;
   localparam int ACC_W   = (YEAR_BITS + 18 > 28) ? YEAR_BITS + 18 : 28;
   localparam int CNT_W   = $clog2(ACC_W);
   localparam int PER_W   = cdw_pkg::PER_W;

   // configuration registers
   logic [7:0] week_length_ff;
   logic [8:0] week_offset_ff;
   logic [4:0] month_count_ff;
   logic [2:0] leap_count_ff;

   // tables
   logic [cdw_pkg::DAYS_W-1:0] month_mem [MAX_MONTHS];
   logic [MAX_MONTHS-1:0]      month_valid_ff;
   logic [cdw_pkg::DAYS_W-1:0] month_rd_ff;
   logic                       month_rd_vld_ff;
   cdw_pkg::rule_entry_type    rule_mem [RDEPTH];
   logic [RDEPTH-1:0]          rule_valid_ff;
   cdw_pkg::rule_entry_type    rule_rd_ff;
   logic                       rule_rd_vld_ff;
   logic [3:0]                 leap_target_ff  [MAX_LEAPS];
   logic [PER_W-1:0]           leap_period_ff  [MAX_LEAPS];
   logic [PER_W-1:0]           leap_phase_ff   [MAX_LEAPS];
   logic [cdw_pkg::DAYS_W-1:0] leap_added_ff   [MAX_LEAPS];
   logic [MAX_LEAPS-1:0]       leap_week_ff;

   // sequencer
   cdw_pkg::state_type state_ff, state_in;
   logic [YEAR_BITS-1:0]       yr_ff, yr_in, y_ff, y_in;
   logic [3:0]                 mon_ff, mon_in;
   logic [9:0]                 dy_ff, dy_in;
   logic [4:0]                 mi_ff, mi_in;
   logic [2:0]                 l_ff, l_in;
   logic [KC_W-1:0]            k_ff, k_in;
   logic [cdw_pkg::BASE_W-1:0] base_ff, base_in, pre_ff, pre_in;
   logic signed [ACC_W-1:0]    all_ff, all_in, wk_ff, wk_in;
   logic [cdw_pkg::YLEN_W-1:0] yl_ff, yl_in;
   logic [7:0]                 wd_ff, wd_in;
   logic                       found_ff, found_in, bhap_ff, bhap_in, app_ff, app_in;
   logic [7:0]                 bprio_ff, bprio_in;
   logic                       neg_ff, neg_in;

   // shared divider
   logic [ACC_W-1:0]  div_q_ff;
   logic [PER_W-1:0]  div_rem_ff, div_den_ff;
   logic [CNT_W-1:0]  div_cnt_ff;
   logic              div_busy_ff;
   logic              div_start;
   logic [ACC_W-1:0]  div_num;
   logic [PER_W-1:0]  div_den;
   logic [CNT_W-1:0]  div_len;
   logic [PER_W:0]    div_trial;

   logic                       req_fire, cfg_fire;
   logic [4:0]                 nm;
   logic [3:0]                 nl;
   logic [4:0]                 lim;
   logic [MI_W-1:0]            m_addr;
   logic [RA_W-1:0]            r_addr;
   logic [LI_W-1:0]            lidx;
   logic [DIFF_W-1:0]          y_ext, ph_ext, diff;
   logic signed [ACC_W-1:0]    wv;
   logic [ACC_W-1:0]           product;
   cdw_pkg::rule_entry_type    rule_wr;

   assign req_fire  = req_valid && req_ready;
   assign cfg_fire  = psel && penable && pwrite && pready;
   assign req_ready = (state_ff == cdw_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == cdw_pkg::ST_OUT);
   assign pready    = 1'b1;
   assign rsp_absolute_day = all_ff[cdw_pkg::ABS_W-1:0];
   assign rsp_weekday      = wd_ff;
   assign rsp_year_length  = yl_ff;

   assign nm  = (32'(month_count_ff) < MAX_MONTHS) ? month_count_ff : 5'(MAX_MONTHS);
   assign nl  = (32'(leap_count_ff) < MAX_LEAPS) ? {1'b0, leap_count_ff} : 4'(MAX_LEAPS);
   assign lim = ({1'b0, mon_ff} < nm) ? {1'b0, mon_ff} : nm;
   assign m_addr = MI_W'(mi_ff);
   assign r_addr = RA_W'(32'(l_ff) * MAX_RULES + 32'(k_ff));
   assign lidx   = LI_W'(l_ff);
   assign y_ext  = DIFF_W'(y_ff);
   assign ph_ext = DIFF_W'(leap_phase_ff[lidx]);
   assign diff   = (y_ext >= ph_ext) ? y_ext - ph_ext : ph_ext - y_ext;
   assign wv     = wk_ff + ACC_W'(signed'(week_offset_ff));
   assign product = ACC_W'(yr_ff) * ACC_W'(base_ff);
   assign div_trial = {div_rem_ff, div_q_ff[div_cnt_ff]};

   assign rule_wr.period  = req_period;
   assign rule_wr.phase   = req_phase;
   assign rule_wr.prio    = req_priority_req;
   assign rule_wr.happens = req_flag;

   always_comb begin
      case (paddr[3:2])
         cdw_pkg::REG_WEEK_LENGTH: prdata = {24'd0, week_length_ff};
         cdw_pkg::REG_WEEK_OFFSET: prdata = {23'd0, week_offset_ff};
         cdw_pkg::REG_MONTH_COUNT: prdata = {27'd0, month_count_ff};
         cdw_pkg::REG_LEAP_COUNT:  prdata = {29'd0, leap_count_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         week_length_ff <= 8'd7;
         week_offset_ff <= 9'd0;
         month_count_ff <= 5'd12;
         leap_count_ff  <= 3'd0;
      end else if (cfg_fire) begin
         case (paddr[3:2])
            cdw_pkg::REG_WEEK_LENGTH: week_length_ff <= pwdata[7:0];
            cdw_pkg::REG_WEEK_OFFSET: week_offset_ff <= pwdata[8:0];
            cdw_pkg::REG_MONTH_COUNT: month_count_ff <= pwdata[4:0];
            cdw_pkg::REG_LEAP_COUNT:  leap_count_ff  <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // month table
   always_ff @(posedge clock) begin
      if (req_fire && req_mode == cdw_pkg::MODE_MONTH && 32'(req_table_slot) < MAX_MONTHS) begin
         month_mem[MI_W'(req_table_slot)] <= req_day_count;
      end
      month_rd_ff <= month_mem[m_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         month_valid_ff  <= '0;
         month_rd_vld_ff <= 1'b0;
      end else begin
         if (req_fire && req_mode == cdw_pkg::MODE_MONTH &&
             32'(req_table_slot) < MAX_MONTHS) begin
            month_valid_ff[MI_W'(req_table_slot)] <= 1'b1;
         end
         month_rd_vld_ff <= month_valid_ff[m_addr];
      end
   end

   // exception table
   always_ff @(posedge clock) begin
      if (req_fire && req_mode == cdw_pkg::MODE_EXC && 32'(req_table_slot) < MAX_LEAPS &&
          32'(req_rule_slot) < MAX_RULES) begin
         rule_mem[RA_W'(32'(req_table_slot) * MAX_RULES + 32'(req_rule_slot))] <= rule_wr;
      end
      rule_rd_ff <= rule_mem[r_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_valid_ff  <= '0;
         rule_rd_vld_ff <= 1'b0;
      end else begin
         if (req_fire && req_mode == cdw_pkg::MODE_EXC && 32'(req_table_slot) < MAX_LEAPS &&
             32'(req_rule_slot) < MAX_RULES) begin
            rule_valid_ff[RA_W'(32'(req_table_slot) * MAX_RULES + 32'(req_rule_slot))]
               <= req_entry_valid;
         end
         rule_rd_vld_ff <= rule_valid_ff[r_addr];
      end
   end

   // leap rule table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEAPS; i++) begin
            leap_target_ff[i] <= '0;
            leap_period_ff[i] <= '0;
            leap_phase_ff[i]  <= '0;
            leap_added_ff[i]  <= '0;
         end
         leap_week_ff <= '0;
      end else if (req_fire && req_mode == cdw_pkg::MODE_LEAP &&
                   32'(req_table_slot) < MAX_LEAPS) begin
         leap_target_ff[LI_W'(req_table_slot)] <= req_month;
         leap_period_ff[LI_W'(req_table_slot)] <= req_period;
         leap_phase_ff[LI_W'(req_table_slot)]  <= req_phase;
         leap_added_ff[LI_W'(req_table_slot)]  <= req_day_count;
         leap_week_ff[LI_W'(req_table_slot)]   <= req_flag;
      end
   end

   // shared restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == '0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_q_ff   <= div_num;
         div_den_ff <= div_den;
         div_cnt_ff <= div_len;
         div_rem_ff <= '0;
      end else if (div_busy_ff) begin
         if (div_trial >= {1'b0, div_den_ff}) begin
            div_rem_ff <= PER_W'(div_trial - {1'b0, div_den_ff});
         end else begin
            div_rem_ff <= div_trial[PER_W-1:0];
         end
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      yr_in = yr_ff;  y_in = y_ff;  mon_in = mon_ff;  dy_in = dy_ff;
      mi_in = mi_ff;  l_in = l_ff;  k_in = k_ff;
      base_in = base_ff;  pre_in = pre_ff;
      all_in = all_ff;  wk_in = wk_ff;  yl_in = yl_ff;  wd_in = wd_ff;
      found_in = found_ff;  bhap_in = bhap_ff;  bprio_in = bprio_ff;
      app_in = app_ff;  neg_in = neg_ff;
      div_start = 1'b0;
      div_num = ACC_W'(y_ff);
      div_den = rule_rd_ff.period;
      div_len = CNT_W'(DIFF_W - 1);
      case (state_ff)
         cdw_pkg::ST_IDLE: begin
            if (req_fire && req_mode == cdw_pkg::MODE_QUERY) begin
               yr_in = req_year;  mon_in = req_month;  dy_in = req_day;
               mi_in = '0;  base_in = '0;  pre_in = '0;
               state_in = cdw_pkg::ST_MRD;
            end
         end
         cdw_pkg::ST_MRD: begin
            state_in = (mi_ff < nm) ? cdw_pkg::ST_MADD : cdw_pkg::ST_MUL;
         end
         cdw_pkg::ST_MADD: begin
            if (month_rd_vld_ff) begin
               base_in = base_ff + cdw_pkg::BASE_W'(month_rd_ff);
               if (mi_ff < {1'b0, mon_ff}) begin
                  pre_in = pre_ff + cdw_pkg::BASE_W'(month_rd_ff);
               end
            end
            mi_in = mi_ff + 1'b1;
            state_in = cdw_pkg::ST_MRD;
         end
         cdw_pkg::ST_MUL: begin
            all_in = signed'(product);
            wk_in  = signed'(product);
            yl_in  = cdw_pkg::YLEN_W'(base_ff);
            y_in = '0;  l_in = '0;  k_in = '0;  found_in = 1'b0;
            state_in = (nl == 4'd0) ? cdw_pkg::ST_WK : cdw_pkg::ST_RRD;
         end
         cdw_pkg::ST_RRD: begin
            state_in = (32'(k_ff) < MAX_RULES) ? cdw_pkg::ST_RCHK : cdw_pkg::ST_BASE;
         end
         cdw_pkg::ST_RCHK: begin
            if (rule_rd_vld_ff && rule_rd_ff.period != '0) begin
               div_start = 1'b1;
               state_in = cdw_pkg::ST_RDIV;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = cdw_pkg::ST_RRD;
            end
         end
         cdw_pkg::ST_RDIV: begin
            if (!div_busy_ff) begin
               if (div_rem_ff == rule_rd_ff.phase &&
                   (!found_ff || rule_rd_ff.prio > bprio_ff)) begin
                  found_in = 1'b1;
                  bprio_in = rule_rd_ff.prio;
                  bhap_in  = rule_rd_ff.happens;
               end
               k_in = k_ff + 1'b1;
               state_in = cdw_pkg::ST_RRD;
            end
         end
         cdw_pkg::ST_BASE: begin
            if (found_ff) begin
               app_in = bhap_ff;
               state_in = cdw_pkg::ST_ACC;
            end else if (leap_period_ff[lidx] == '0) begin
               app_in = 1'b0;
               state_in = cdw_pkg::ST_ACC;
            end else begin
               div_start = 1'b1;
               div_num = ACC_W'(diff);
               div_den = leap_period_ff[lidx];
               state_in = cdw_pkg::ST_BDIV;
            end
         end
         cdw_pkg::ST_BDIV: begin
            if (!div_busy_ff) begin
               app_in = (div_rem_ff == '0);
               state_in = cdw_pkg::ST_ACC;
            end
         end
         cdw_pkg::ST_ACC: begin
            if (app_ff) begin
               if (y_ff != yr_ff) begin
                  all_in = all_ff + ACC_W'(leap_added_ff[lidx]);
                  if (leap_week_ff[lidx]) begin
                     wk_in = wk_ff + ACC_W'(leap_added_ff[lidx]);
                  end
               end else begin
                  yl_in = yl_ff + cdw_pkg::YLEN_W'(leap_added_ff[lidx]);
                  if ({1'b0, leap_target_ff[lidx]} < lim) begin
                     all_in = all_ff + ACC_W'(leap_added_ff[lidx]);
                     if (leap_week_ff[lidx]) begin
                        wk_in = wk_ff + ACC_W'(leap_added_ff[lidx]);
                     end
                  end
               end
            end
            k_in = '0;
            found_in = 1'b0;
            if ({1'b0, l_ff} + 4'd1 == nl) begin
               l_in = '0;
               if (y_ff == yr_ff) begin
                  state_in = cdw_pkg::ST_WK;
               end else begin
                  y_in = y_ff + 1'b1;
                  state_in = cdw_pkg::ST_RRD;
               end
            end else begin
               l_in = l_ff + 1'b1;
               state_in = cdw_pkg::ST_RRD;
            end
         end
         cdw_pkg::ST_WK: begin
            all_in = all_ff + ACC_W'(pre_ff) + ACC_W'(dy_ff) - ACC_W'(1);
            wk_in  = wk_ff + ACC_W'(pre_ff) + ACC_W'(dy_ff) - ACC_W'(1);
            state_in = cdw_pkg::ST_WMOD;
         end
         cdw_pkg::ST_WMOD: begin
            if (week_length_ff == 8'd0) begin
               wd_in = 8'd0;
               state_in = cdw_pkg::ST_OUT;
            end else begin
               neg_in = wv[ACC_W-1];
               div_start = 1'b1;
               div_num = wv[ACC_W-1] ? ACC_W'(-wv) : ACC_W'(wv);
               div_den = PER_W'(week_length_ff);
               div_len = CNT_W'(ACC_W - 1);
               state_in = cdw_pkg::ST_WDIV;
            end
         end
         cdw_pkg::ST_WDIV: begin
            if (!div_busy_ff) begin
               if (neg_ff && div_rem_ff != '0) begin
                  wd_in = week_length_ff - div_rem_ff[7:0];
               end else begin
                  wd_in = div_rem_ff[7:0];
               end
               state_in = cdw_pkg::ST_OUT;
            end
         end
         cdw_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = cdw_pkg::ST_IDLE;
            end
         end
         default: state_in = cdw_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      yr_ff <= yr_in;  y_ff <= y_in;  mon_ff <= mon_in;  dy_ff <= dy_in;
      mi_ff <= mi_in;  l_ff <= l_in;  k_ff <= k_in;
      base_ff <= base_in;  pre_ff <= pre_in;
      all_ff <= all_in;  wk_ff <= wk_in;  yl_ff <= yl_in;  wd_ff <= wd_in;
      found_ff <= found_in;  bhap_ff <= bhap_in;  bprio_ff <= bprio_in;
      app_ff <= app_in;  neg_ff <= neg_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (state_ff == cdw_pkg::ST_RDIV || state_ff == cdw_pkg::ST_BDIV ||
                       state_ff == cdw_pkg::ST_WDIV)) else $error("divider busy out of turn");

   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready) else $error("no return to idle");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && week_length_ff != 8'd0) |-> (rsp_weekday < week_length_ff))
      else $error("weekday out of range");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar day number and weekday testbench
// Writes month, leap rule and exception tables, queries dates and checks
// absolute day, weekday and year length against a local predictor, across
// several register settings and under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  tslot;
      logic [1:0]  rslot;
      logic [9:0]  dcount;
      logic [11:0] per;
      logic [11:0] pha;
      logic [3:0]  mon;
      logic [7:0]  prio;
      logic        flg;
      logic        ev;
      logic [11:0] yr;
      logic [9:0]  dy;
      logic        typed;
      logic [26:0] t_abs;
      logic [7:0]  t_wd;
      logic [14:0] t_yl;
   } date_beat_type;

   typedef struct packed {
      logic [26:0] abs_day;
      logic [7:0]  wd;
      logic [14:0] yl;
   } date_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = cdw_pkg::MODE_MONTH;
   logic [3:0]  req_table_slot = '0;
   logic [1:0]  req_rule_slot = '0;
   logic [9:0]  req_day_count = '0;
   logic [11:0] req_period = '0;
   logic [11:0] req_phase = '0;
   logic [3:0]  req_month = '0;
   logic [7:0]  req_priority_req = '0;
   logic        req_flag = 1'b0;
   logic        req_entry_valid = 1'b0;
   logic [11:0] req_year = '0;
   logic [9:0]  req_day = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [26:0] rsp_absolute_day;
   logic [7:0]  rsp_weekday;
   logic [14:0] rsp_year_length;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [cdw_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   calendar_day_number_weekday i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_table_slot(req_table_slot),
      .req_rule_slot(req_rule_slot), .req_day_count(req_day_count),
      .req_period(req_period), .req_phase(req_phase), .req_month(req_month),
      .req_priority_req(req_priority_req), .req_flag(req_flag),
      .req_entry_valid(req_entry_valid), .req_year(req_year), .req_day(req_day),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_absolute_day(rsp_absolute_day), .rsp_weekday(rsp_weekday),
      .rsp_year_length(rsp_year_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // calendar state
   int unsigned week_len, month_cnt, leap_cnt;
   int          week_off;
   int unsigned mdays[16];
   int unsigned lp_target[4], lp_period[4], lp_phase[4], lp_added[4];
   bit          lp_week[4];
   int unsigned ex_period[16], ex_phase[16], ex_prio[16];
   bit          ex_happens[16], ex_valid[16];

   date_result_type dates_due[$];
   int errors = 0;
   int snd_idle = 0;
   int rcv_idle = 0;
   int hold_left = 0;

   function automatic bit leap_hits(int unsigned yr, int unsigned lr);
      int best;
      int unsigned s, diff;
      best = -1;
      for (int k = 0; k < 4; k++) begin
         s = lr * 4 + k;
         if (!ex_valid[s] || ex_period[s] == 0) continue;
         if (yr % ex_period[s] != ex_phase[s]) continue;
         if (best < 0 || ex_prio[s] > ex_prio[best]) best = s;
      end
      if (best >= 0) return ex_happens[best];
      if (lp_period[lr] == 0) return 1'b0;
      diff = (yr >= lp_phase[lr]) ? yr - lp_phase[lr] : lp_phase[lr] - yr;
      return (diff % lp_period[lr]) == 0;
   endfunction

   function automatic date_result_type predict_date(date_beat_type b);
      longint base, all_d, wk_d, ylen, wd;
      int unsigned nm, nl, yr;
      date_result_type r;
      nm = (month_cnt < 16) ? month_cnt : 16;
      nl = (leap_cnt < 4) ? leap_cnt : 4;
      yr = b.yr;
      base = 0;
      for (int i = 0; i < nm; i++) base += mdays[i];
      all_d = longint'(yr) * base;
      wk_d = all_d;
      for (int unsigned y = 0; y < yr; y++)
         for (int l = 0; l < nl; l++)
            if (leap_hits(y, l)) begin
               all_d += lp_added[l];
               if (lp_week[l]) wk_d += lp_added[l];
            end
      ylen = base;
      for (int l = 0; l < nl; l++)
         if (leap_hits(yr, l)) ylen += lp_added[l];
      for (int i = 0; i < b.mon && i < nm; i++) begin
         all_d += mdays[i];
         wk_d += mdays[i];
         for (int l = 0; l < nl; l++)
            if (lp_target[l] == i && leap_hits(yr, l)) begin
               all_d += lp_added[l];
               if (lp_week[l]) wk_d += lp_added[l];
            end
      end
      all_d += longint'(b.dy) - 1;
      wk_d += longint'(b.dy) - 1;
      if (week_len == 0) begin
         wd = 0;
      end else begin
         wd = (wk_d + week_off) % longint'(week_len);
         if (wd < 0) wd += week_len;
      end
      r.abs_day = all_d[26:0];
      r.wd = wd[7:0];
      r.yl = ylen[14:0];
      return r;
   endfunction

   function automatic void store_entry(date_beat_type b);
      int unsigned s;
      case (b.mode)
         cdw_pkg::MODE_MONTH: begin
            mdays[b.tslot] = b.dcount;
         end
         cdw_pkg::MODE_LEAP: begin
            if (b.tslot < 4) begin
               lp_target[b.tslot] = b.mon;
               lp_period[b.tslot] = b.per;
               lp_phase[b.tslot] = b.pha;
               lp_added[b.tslot] = b.dcount;
               lp_week[b.tslot] = b.flg;
            end
         end
         cdw_pkg::MODE_EXC: begin
            if (b.tslot < 4) begin
               s = b.tslot * 4 + b.rslot;
               ex_period[s] = b.per;
               ex_phase[s] = b.pha;
               ex_prio[s] = b.prio;
               ex_happens[s] = b.flg;
               ex_valid[s] = b.ev;
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_beat(date_beat_type b);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_mode <= b.mode;
      req_table_slot <= b.tslot;
      req_rule_slot <= b.rslot;
      req_day_count <= b.dcount;
      req_period <= b.per;
      req_phase <= b.pha;
      req_month <= b.mon;
      req_priority_req <= b.prio;
      req_flag <= b.flg;
      req_entry_valid <= b.ev;
      req_year <= b.yr;
      req_day <= b.dy;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (b.mode == cdw_pkg::MODE_QUERY) begin
         if (b.typed) dates_due.push_back({b.t_abs, b.t_wd, b.t_yl});
         else dates_due.push_back(predict_date(b));
      end else begin
         store_entry(b);
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      req_valid <= 1'b0;
      while (dates_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         cdw_pkg::REG_WEEK_LENGTH: week_len = val[7:0];
         cdw_pkg::REG_WEEK_OFFSET: week_off = $signed(val[8:0]);
         cdw_pkg::REG_MONTH_COUNT: month_cnt = val[4:0];
         default:                  leap_cnt = val[2:0];
      endcase
   endtask

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (dates_due.size() == 0) begin
            $display("%0t unexpected result beat: abs %0d wd %0d ylen %0d", $time,
                     rsp_absolute_day, rsp_weekday, rsp_year_length);
            errors++;
         end else begin
            if (rsp_absolute_day !== dates_due[0].abs_day) begin
               $display("%0t absolute_day expected %0d actual %0d", $time,
                        dates_due[0].abs_day, rsp_absolute_day);
               errors++;
            end
            if (rsp_weekday !== dates_due[0].wd) begin
               $display("%0t weekday expected %0d actual %0d", $time,
                        dates_due[0].wd, rsp_weekday);
               errors++;
            end
            if (rsp_year_length !== dates_due[0].yl) begin
               $display("%0t year_length expected %0d actual %0d", $time,
                        dates_due[0].yl, rsp_year_length);
               errors++;
            end
            void'(dates_due.pop_front());
         end
      end
   end

   localparam int DIRECTED = 19;
   localparam date_beat_type PLAN [DIRECTED] = '{
      // mode               ts rs dc   per   pha  mon prio flg ev yr   dy  typed abs wd yl
      '{cdw_pkg::MODE_QUERY, 0, 0, 0,    0,    0,    0, 0,   0, 0, 0,    1,    1, 0, 0, 0},
      '{cdw_pkg::MODE_QUERY, 0, 0, 0,    0,    0,    0, 0,   0, 0, 0,    0,    1,
        27'h7FFFFFF, 6, 0},
      '{cdw_pkg::MODE_QUERY, 0, 0, 0,    0,    0,   15, 0,   0, 0, 4095, 1023, 1, 1022, 0, 0},
      '{cdw_pkg::MODE_MONTH, 0, 0, 31,   0,    0,    0, 0,   0, 0, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_MONTH, 1, 0, 1023, 0,    0,    0, 0,   0, 0, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_MONTH, 15, 3, 30, 4095, 4095, 15, 255, 1, 1, 4095, 1023, 0, 0, 0, 0},
      '{cdw_pkg::MODE_MONTH, 2, 0, 28,   0,    0,    0, 0,   0, 0, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_LEAP,  0, 0, 1,    4,    0,    1, 0,   1, 0, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_LEAP,  3, 0, 1023, 4095, 4095, 15, 0,  0, 0, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_LEAP,  15, 0, 5,   2,    0,    0, 0,   1, 0, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_EXC,   0, 0, 0,    100,  0,    0, 5,   0, 1, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_EXC,   0, 1, 0,    400,  0,    0, 9,   1, 1, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_EXC,   0, 2, 0,    0,    0,    0, 255, 0, 1, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_EXC,   0, 3, 0,    3,    5,    0, 255, 0, 1, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_EXC,   15, 3, 0,   7,    1,    0, 1,   1, 1, 0,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_EXC,   3, 3, 1023, 4095, 4095, 15, 255, 1, 0, 0,   0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_QUERY, 0, 0, 0,    0,    0,   15, 0,   0, 0, 2,    0,    0, 0, 0, 0},
      '{cdw_pkg::MODE_QUERY, 0, 0, 0,    0,    0,    2, 0,   0, 0, 7,    5,    0, 0, 0, 0},
      '{cdw_pkg::MODE_QUERY, 0, 0, 0,    0,    0,   12, 0,   0, 0, 3,    1023, 0, 0, 0, 0}
   };

   initial begin
      date_beat_type b;
      int sel;
      int wl_set [5] = '{255, 0, 7, 1, 13};
      int off_set[5] = '{255, -255, -1, 0, 100};
      int mc_set [5] = '{16, 31, 5, 0, 12};
      int lc_set [5] = '{4, 7, 2, 4, 3};

      week_len = 7;
      week_off = 0;
      month_cnt = 12;
      leap_cnt = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      rcv_idle = 0;
      @(posedge clock);
      for (int n = 0; n < DIRECTED; n++) send_beat(PLAN[n]);

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(cdw_pkg::REG_WEEK_LENGTH, wl_set[ph]);
         write_reg(cdw_pkg::REG_WEEK_OFFSET, off_set[ph] & 32'h1FF);
         write_reg(cdw_pkg::REG_MONTH_COUNT, mc_set[ph]);
         write_reg(cdw_pkg::REG_LEAP_COUNT, lc_set[ph]);
         snd_idle = (ph < 2) ? 11 : (ph < 4) ? 50 : 0;
         rcv_idle = (ph < 2) ? 50 : (ph < 4) ? 11 : 0;
         if (ph == 0) hold_left = 20000;
         for (int n = 0; n < 20; n++) begin
            b = '0;
            b.tslot = $urandom_range(0, 15);
            b.rslot = $urandom_range(0, 3);
            b.dcount = $urandom_range(0, 1023);
            b.mon = $urandom_range(0, 15);
            b.prio = $urandom_range(0, 255);
            b.flg = $urandom_range(0, 1);
            b.ev = $urandom_range(0, 1);
            b.dy = $urandom_range(0, 1023);
            sel = $urandom_range(99);
            if ($urandom_range(3) == 0) begin
               b.per = $urandom_range(0, 4095);
               b.pha = $urandom_range(0, 4095);
            end else begin
               b.per = $urandom_range(0, 8);
               b.pha = $urandom_range(0, 8);
            end
            // keep queries short: few years, mostly small table slots for leap and exception writes
            if (sel < 35) begin
               b.mode = cdw_pkg::MODE_QUERY;
               b.yr = $urandom_range(0, 24);
            end else if (sel < 60) begin
               b.mode = cdw_pkg::MODE_MONTH;
               b.dcount = $urandom_range(0, 3) == 0 ? b.dcount : $urandom_range(0, 40);
               b.yr = $urandom_range(0, 4095);
            end else if (sel < 80) begin
               b.mode = cdw_pkg::MODE_LEAP;
               if ($urandom_range(4) != 0) b.tslot = $urandom_range(0, 3);
               b.yr = $urandom_range(0, 4095);
            end else begin
               b.mode = cdw_pkg::MODE_EXC;
               if ($urandom_range(4) != 0) b.tslot = $urandom_range(0, 3);
               b.yr = $urandom_range(0, 4095);
            end
            send_beat(b);
         end
      end

      req_valid <= 1'b0;
      while (dates_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- calendar_day_number_weekday.f -----
sv/cdw_pkg.sv
sv/calendar_day_number_weekday.sv
tb/testbench.sv
